// File: rtl/bxor_pkg.sv
// Shared constants and types for the binary trie maximum-XOR block.
// No dependencies; compiled first.
package bxor_pkg;

  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned NODE_COUNT_DEF = 4096;

  localparam int KEY_W     = 32;
  localparam int MAX_XOR_W = 32;
  localparam int STATUS_W  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_FINISH
  } state_t;

endpackage

// File: rtl/bxor_req_if.sv
// Request channel: command and key, valid/ready handshake.
// Depends on bxor_pkg.
interface bxor_req_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [bxor_pkg::KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

// File: rtl/bxor_res_if.sv
// Result channel: maximum XOR and status, valid/ready handshake.
// Depends on bxor_pkg.
interface bxor_res_if;
  logic                          valid;
  logic                          ready;
  logic [bxor_pkg::MAX_XOR_W-1:0] max_xor;
  logic [bxor_pkg::STATUS_W-1:0]  status;

  modport source (output valid, max_xor, status, input ready);
  modport sink   (input valid, max_xor, status, output ready);
endinterface

// File: rtl/bxor_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bxor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/binary_trie_max_xor.sv
// Top level of the binary trie maximum-XOR engine: FSM, walk datapath, node table.
// Depends on bxor_pkg, bxor_req_if, bxor_res_if and bxor_ram.
//
//   channel  dir  fields                    meaning
//   req      in   cmd[0:0], key[31:0]       insert key (0) or max-XOR query (1)
//   res      out  max_xor[31:0], status[1:0] one result per request
//
// A request walks one trie level per cycle, reading each node the cycle before.
// An empty-set query skips the walk. An allocating insert walks to the missing
// link, then does one parent-link write and one write per new node; a dropped
// insert ends at that link.
// No clearing pass after reset: root links sit in flops, other nodes are written
// when allocated. A stalled result waits in the output register while the next
// request is taken; a request finishing behind it waits in S_FINISH.
module binary_trie_max_xor #(
  parameter int unsigned KEY_BITS   = bxor_pkg::KEY_BITS_DEF,
  parameter int unsigned NODE_COUNT = bxor_pkg::NODE_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  bxor_req_if.sink   req,
  bxor_res_if.source res
);
  import bxor_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(KEY_BITS);
  localparam int UW = NW + 1;
  localparam int CW = (UW > LW + 1) ? UW : LW + 1;

  state_t                  state, state_next;
  logic                    cmd_r, cmd_r_next;
  logic [KEY_BITS-1:0]     key_r, key_r_next;
  logic [LW-1:0]           lvl, lvl_next;
  logic [NW-1:0]           cur, cur_next;
  logic [KEY_BITS-1:0]     best, best_next;
  logic [NW-1:0]           par_node, par_node_next;
  logic [2*NW-1:0]         par_links, par_links_next;
  logic                    par_phase, par_phase_next;
  logic [UW-1:0]           nodes_used, nodes_used_next;
  logic                    set_nonempty, set_nonempty_next;
  logic [2*NW-1:0]         root_links, root_links_next;
  logic [STATUS_W-1:0]     stat, stat_next;
  logic                    out_valid, out_valid_next;
  logic [MAX_XOR_W-1:0]    out_xor, out_xor_next;
  logic [STATUS_W-1:0]     out_status, out_status_next;

  logic                    ram_we;
  logic [NW-1:0]           ram_waddr, ram_raddr;
  logic [2*NW-1:0]         ram_wdata, ram_rdata;

  logic [2*NW-1:0]         links;
  logic                    bit_k, bit_below;
  logic [NW-1:0]           same, opp, nx, new_idx, new_next;
  logic [CW-1:0]           need, avail;
  logic [KEY_BITS+KEY_W-1:0]     key_ext;
  logic [KEY_BITS+MAX_XOR_W-1:0] best_ext;
  logic [2*NW-1:0]         parent_data, node_data;

  bxor_ram #(
    .WIDTH (2 * NW),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // root lives in flops, so node 0 is never read from the RAM
  assign links    = (cur == '0) ? root_links : ram_rdata;
  assign bit_k    = key_r[lvl];
  assign same     = bit_k ? links[2*NW-1:NW] : links[NW-1:0];
  assign opp      = bit_k ? links[NW-1:0] : links[2*NW-1:NW];
  assign nx       = (cmd_r == CMD_QUERY && opp != '0) ? opp : same;
  assign need     = CW'(lvl) + CW'(1);
  assign avail    = CW'(NODE_COUNT) - CW'(nodes_used);
  assign key_ext  = {{KEY_BITS{1'b0}}, req.key};
  assign best_ext = {{MAX_XOR_W{1'b0}}, best};

  assign new_idx   = nodes_used[NW-1:0];
  assign new_next  = new_idx + NW'(1);
  assign bit_below = (lvl == '0) ? 1'b0 : key_r[lvl - LW'(1)];
  assign parent_data = bit_k ? {new_idx, par_links[NW-1:0]}
                             : {par_links[2*NW-1:NW], new_idx};
  // leaf gets no links; inner new node points to the next one in the chain
  assign node_data = (lvl == '0) ? '0
                   : (bit_below ? {new_next, {NW{1'b0}}} : {{NW{1'b0}}, new_next});

  assign ram_raddr = nx;
  assign ram_we    = (state == S_ALLOC) && !(par_phase && par_node == '0);
  assign ram_waddr = par_phase ? par_node : new_idx;
  assign ram_wdata = par_phase ? parent_data : node_data;

  assign req.ready   = (state == S_IDLE);
  assign res.valid   = out_valid;
  assign res.max_xor = out_xor;
  assign res.status  = out_status;

  always_comb begin
    state_next        = state;
    cmd_r_next        = cmd_r;
    key_r_next        = key_r;
    lvl_next          = lvl;
    cur_next          = cur;
    best_next         = best;
    par_node_next     = par_node;
    par_links_next    = par_links;
    par_phase_next    = par_phase;
    nodes_used_next   = nodes_used;
    set_nonempty_next = set_nonempty;
    root_links_next   = root_links;
    stat_next         = stat;
    out_valid_next    = out_valid && !res.ready;
    out_xor_next      = out_xor;
    out_status_next   = out_status;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_r_next = req.cmd;
          key_r_next = key_ext[KEY_BITS-1:0];
          lvl_next   = LW'(KEY_BITS - 1);
          cur_next   = '0;
          best_next  = '0;
          if (req.cmd == CMD_QUERY && !set_nonempty) begin
            stat_next  = STATUS_EMPTY;
            state_next = S_FINISH;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (cmd_r == CMD_INSERT) begin
          if (same == '0) begin
            if (need > avail) begin
              stat_next  = STATUS_FULL;
              state_next = S_FINISH;
            end else begin
              par_node_next  = cur;
              par_links_next = links;
              par_phase_next = 1'b1;
              state_next     = S_ALLOC;
            end
          end else if (lvl == '0) begin
            stat_next  = STATUS_OK;
            state_next = S_FINISH;
          end else begin
            cur_next = same;
            lvl_next = lvl - LW'(1);
          end
        end else begin
          if (opp != '0) begin
            best_next[lvl] = 1'b1;
          end
          // a node with no child at all ends the walk early
          if (nx == '0 || lvl == '0) begin
            stat_next  = STATUS_OK;
            state_next = S_FINISH;
          end else begin
            cur_next = nx;
            lvl_next = lvl - LW'(1);
          end
        end
      end
      S_ALLOC: begin
        if (par_phase) begin
          par_phase_next = 1'b0;
          if (par_node == '0) begin
            root_links_next = parent_data;
          end
        end else begin
          nodes_used_next = nodes_used + UW'(1);
          if (lvl == '0) begin
            set_nonempty_next = 1'b1;
            stat_next         = STATUS_OK;
            state_next        = S_FINISH;
          end else begin
            lvl_next = lvl - LW'(1);
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || res.ready) begin
          out_valid_next  = 1'b1;
          out_xor_next    = (cmd_r == CMD_QUERY && stat == STATUS_OK)
                            ? best_ext[MAX_XOR_W-1:0] : '0;
          out_status_next = stat;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      par_phase    <= 1'b0;
      nodes_used   <= UW'(1);
      set_nonempty <= 1'b0;
      root_links   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      par_phase    <= par_phase_next;
      nodes_used   <= nodes_used_next;
      set_nonempty <= set_nonempty_next;
      root_links   <= root_links_next;
      out_valid    <= out_valid_next;
    end
    cmd_r      <= cmd_r_next;
    key_r      <= key_r_next;
    lvl        <= lvl_next;
    cur        <= cur_next;
    best       <= best_next;
    par_node   <= par_node_next;
    par_links  <= par_links_next;
    stat       <= stat_next;
    out_xor    <= out_xor_next;
    out_status <= out_status_next;
  end

endmodule

// File: rtl/bxor_checker.sv
// Port-level checks for binary_trie_max_xor, attached by bind.
// Depends on bxor_pkg and the top level.
module bxor_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [bxor_pkg::MAX_XOR_W-1:0] res_max_xor,
  input logic [bxor_pkg::STATUS_W-1:0]  res_status
);
  import bxor_pkg::*;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == STATUS_OK || res_status == STATUS_EMPTY ||
                   res_status == STATUS_FULL))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == STATUS_EMPTY || res_status == STATUS_FULL)
      |-> res_max_xor == '0)
    else $error("nonzero max_xor on an error result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_max_xor) && $stable(res_status))
    else $error("stalled result changed");

endmodule

bind binary_trie_max_xor bxor_checker u_bxor_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_max_xor (res.max_xor),
  .res_status  (res.status)
);
